FILE: sv/mqdd_pkg.sv
// ----------------------------------------------------------------------------
// mqdd_pkg - shared types and constants of the quadrature detent decoder
// Field widths, the transition step table, register map and event batch type.
// ----------------------------------------------------------------------------
`default_nettype none

package mqdd_pkg;

  // Pin fields carry at most four encoders
  localparam int unsigned PinLanes = 4;
  localparam int unsigned IdxW     = 2;
  localparam int unsigned AccW     = 5;
  localparam int unsigned ThrW     = 4;

  // APB register map
  localparam int unsigned PAddrW   = 3;
  localparam int unsigned PDataW   = 32;
  localparam logic        RegStepsPerDetent = 1'b0;   // paddr[2] of the register
  localparam logic [ThrW-1:0] StepsResetVal = 4'd4;

  // Events raised by one sample, one bit per lane
  typedef struct packed {
    logic [PinLanes-1:0] hit;
    logic [PinLanes-1:0] ccw;
  } batch_t;

  // Step for transition {previous_ab, current_ab}; bounces give zero
  function automatic logic signed [1:0] step_lut(input logic [3:0] trans);
    logic signed [1:0] s;
    unique case (trans)
      4'h1, 4'h7, 4'h8, 4'hE: s = -2'sd1;
      4'h2, 4'h4, 4'hB, 4'hD: s = 2'sd1;
      default:                s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: sv/mqdd_if.sv
// ----------------------------------------------------------------------------
// mqdd_in_if / mqdd_out_if - valid/ready channels of the detent decoder
// Sample channel and event channel with their payload fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface mqdd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [3:0] pin_a_levels;
  logic [3:0] pin_b_levels;

  modport source (output valid, mode, pin_a_levels, pin_b_levels, input ready);
  modport sink   (input valid, mode, pin_a_levels, pin_b_levels, output ready);
endinterface

interface mqdd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] encoder_index;
  logic       direction;
  logic       last_event;

  modport source (output valid, encoder_index, direction, last_event, input ready);
  modport sink   (input valid, encoder_index, direction, last_event, output ready);
endinterface

`default_nettype wire

FILE: sv/mqdd_apb.sv
// ----------------------------------------------------------------------------
// mqdd_apb - APB configuration register
// Holds steps_per_detent; writes complete on the access phase.
// ----------------------------------------------------------------------------
`default_nettype none

module mqdd_apb (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mqdd_pkg::PAddrW-1:0]   paddr,
  input  wire logic [mqdd_pkg::PDataW-1:0]   pwdata,
  output logic      [mqdd_pkg::PDataW-1:0]   prdata,
  output logic                               pready,
  output logic      [mqdd_pkg::ThrW-1:0]     steps_o
);

  logic [mqdd_pkg::ThrW-1:0] steps_q, steps_d;
  logic                      sel_steps;

  assign sel_steps = (paddr[2] == mqdd_pkg::RegStepsPerDetent);
  assign pready    = 1'b1;

  always_comb begin
    steps_d = steps_q;
    if (psel && penable && pwrite && sel_steps) begin
      steps_d = pwdata[mqdd_pkg::ThrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= mqdd_pkg::StepsResetVal;
    end else begin
      steps_q <= steps_d;
    end
  end

  assign prdata  = sel_steps ? {{(mqdd_pkg::PDataW-mqdd_pkg::ThrW){1'b0}}, steps_q}
                             : '0;
  assign steps_o = steps_q;

endmodule

`default_nettype wire

FILE: sv/mqdd_lane.sv
// ----------------------------------------------------------------------------
// mqdd_lane - one encoder channel
// Stores the last AB state and the step accumulator, flags detent events.
// ----------------------------------------------------------------------------
`default_nettype none

module mqdd_lane (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        capture_i,
  input  wire logic [1:0]                  ab_i,
  input  wire logic [mqdd_pkg::ThrW-1:0]   thr_i,
  output logic                             hit_o,
  output logic                             ccw_o
);

  localparam int unsigned SumW = mqdd_pkg::AccW + 1;

  logic [1:0]                prev_q, prev_d;
  logic [mqdd_pkg::AccW-1:0] acc_q, acc_d;
  logic signed [SumW-1:0]    sum, thr_pos, thr_neg;
  logic signed [1:0]         step;
  logic                      moved;

  assign moved   = (ab_i != prev_q);
  assign step    = mqdd_pkg::step_lut({prev_q, ab_i});
  assign sum     = $signed({acc_q[mqdd_pkg::AccW-1], acc_q}) + SumW'(step);
  assign thr_pos = $signed({{(SumW-mqdd_pkg::ThrW){1'b0}}, thr_i});
  assign thr_neg = -thr_pos;

  always_comb begin
    prev_d = prev_q;
    acc_d  = acc_q;
    hit_o  = 1'b0;
    ccw_o  = 1'b0;
    if (en_i) begin
      if (capture_i) begin
        prev_d = ab_i;
        acc_d  = '0;
      end else if (moved) begin
        prev_d = ab_i;
        acc_d  = sum[mqdd_pkg::AccW-1:0];
        if (sum >= thr_pos) begin
          hit_o = 1'b1;
          acc_d = '0;
        end else if (sum <= thr_neg) begin
          hit_o = 1'b1;
          ccw_o = 1'b1;
          acc_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      acc_q  <= '0;
    end else begin
      prev_q <= prev_d;
      acc_q  <= acc_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mqdd_evq.sv
// ----------------------------------------------------------------------------
// mqdd_evq - event batch register
// Holds the events of one sample and hands them out lowest encoder first.
// ----------------------------------------------------------------------------
`default_nettype none

module mqdd_evq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire mqdd_pkg::batch_t   batch_i,
  output logic                    free_o,
  mqdd_out_if.source              out_m
);

  localparam int unsigned L = mqdd_pkg::PinLanes;

  logic [L-1:0]               hit_q, hit_d, rest;
  logic [L-1:0]               ccw_q, ccw_d;
  logic [mqdd_pkg::IdxW-1:0]  idx;
  logic                       take;

  assign rest = hit_q & (hit_q - L'(1));
  assign take = out_m.valid && out_m.ready;

  // lowest pending encoder
  always_comb begin
    idx = '0;
    for (int i = L - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        idx = mqdd_pkg::IdxW'(i);
      end
    end
  end

  assign free_o = (hit_q == '0) || (take && (rest == '0));

  always_comb begin
    hit_d = hit_q;
    ccw_d = ccw_q;
    if (load_i) begin
      hit_d = batch_i.hit;
      ccw_d = batch_i.ccw;
    end else if (take) begin
      hit_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= '0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ccw_q <= ccw_d;
  end

  assign out_m.valid         = (hit_q != '0);
  assign out_m.encoder_index = idx;
  assign out_m.direction     = ccw_q[idx];
  assign out_m.last_event    = (rest == '0);

endmodule

`default_nettype wire

FILE: sv/multi_quadrature_detent_decoder_core.sv
// ----------------------------------------------------------------------------
// multi_quadrature_detent_decoder_core - multi-encoder quadrature detent decoder
// A sample is registered on accept; when the event register is free, its events
//   are loaded there and the first is offered on the output.
// One sample per cycle when it raises at most one event and the output is not
//   stalled; a sample's k events (k <= 4) hold the event register until taken.
// Reset (async, active low): AB states and accumulators clear, steps = 4.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_quadrature_detent_decoder_core #(
  parameter int unsigned NUM_ENCODERS = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  mqdd_in_if.sink                            in_s,
  mqdd_out_if.source                         out_m,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mqdd_pkg::PAddrW-1:0]   paddr,
  input  wire logic [mqdd_pkg::PDataW-1:0]   pwdata,
  output logic      [mqdd_pkg::PDataW-1:0]   prdata,
  output logic                               pready
);

  // Only the encoders that have pins in the sample fields are built
  localparam int unsigned NumLanes =
    (NUM_ENCODERS > mqdd_pkg::PinLanes) ? mqdd_pkg::PinLanes : NUM_ENCODERS;

  // Configuration register
  logic [mqdd_pkg::ThrW-1:0] steps;

  mqdd_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .steps_o (steps)
  );

  // Input register: one sample waiting for the lanes
  logic                           smp_vld_q, smp_vld_d;
  logic                           mode_q;
  logic [mqdd_pkg::PinLanes-1:0]  pa_q, pb_q;
  logic                           batch_free;
  logic                           fire;
  logic                           in_take;

  // The sample is processed once the event register can take its batch
  assign fire     = smp_vld_q && batch_free;
  assign in_s.ready = !smp_vld_q || fire;
  assign in_take  = in_s.valid && in_s.ready;

  always_comb begin
    smp_vld_d = smp_vld_q;
    if (in_take) begin
      smp_vld_d = 1'b1;
    end else if (fire) begin
      smp_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= 1'b0;
    end else begin
      smp_vld_q <= smp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q <= in_s.mode;
      pa_q   <= in_s.pin_a_levels;
      pb_q   <= in_s.pin_b_levels;
    end
  end

  // Per-encoder lanes; missing lanes report no events
  mqdd_pkg::batch_t batch;

  for (genvar g = 0; g < mqdd_pkg::PinLanes; g++) begin : g_lane
    if (g < NumLanes) begin : g_on
      mqdd_lane u_lane (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .en_i      (fire),
        .capture_i (mode_q),
        .ab_i      ({pa_q[g], pb_q[g]}),
        .thr_i     (steps),
        .hit_o     (batch.hit[g]),
        .ccw_o     (batch.ccw[g])
      );
    end else begin : g_off
      assign batch.hit[g] = 1'b0;
      assign batch.ccw[g] = 1'b0;
    end
  end

  // Event register drains the batch one transaction per cycle while the sink is ready
  mqdd_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .batch_i (batch),
    .free_o  (batch_free),
    .out_m   (out_m)
  );

endmodule

`default_nettype wire

FILE: sv/mqdd_checker.sv
// ----------------------------------------------------------------------------
// mqdd_checker - port-level checks of the detent decoder
// Event ordering within a sample, output stall behavior, register readback.
// ----------------------------------------------------------------------------
`default_nettype none

module mqdd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [1:0]                    out_index,
  input wire logic                          out_dir,
  input wire logic                          out_last,
  input wire logic                          psel,
  input wire logic                          penable,
  input wire logic                          pwrite,
  input wire logic [mqdd_pkg::PAddrW-1:0]   paddr,
  input wire logic [mqdd_pkg::PDataW-1:0]   pwdata,
  input wire logic [mqdd_pkg::PDataW-1:0]   prdata
);

  logic out_take;
  assign out_take = out_valid && out_ready;

  // a stalled event holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_index) &&
                                $stable(out_dir) && $stable(out_last))
    else $error("stalled event changed");

  // more events of the same sample follow without a gap
  a_batch_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !out_last |=> out_valid)
    else $error("event batch broken before its last event");

  // events of one sample come out in ascending encoder order
  a_batch_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !out_last |=> out_index > $past(out_index))
    else $error("event batch out of encoder order");

  // the written threshold reads back
  a_reg_rdbk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr[2] == mqdd_pkg::RegStepsPerDetent
    |=> paddr[2] != mqdd_pkg::RegStepsPerDetent ||
        prdata[mqdd_pkg::ThrW-1:0] == $past(pwdata[mqdd_pkg::ThrW-1:0]))
    else $error("steps_per_detent readback mismatch");

endmodule

bind multi_quadrature_detent_decoder_core mqdd_checker u_mqdd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .out_index (out_m.encoder_index),
  .out_dir   (out_m.direction),
  .out_last  (out_m.last_event),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench of the multi-encoder detent decoder
// Drives Gray-code walks, bounces and baseline captures on all four encoders,
// predicts every detent event and checks each event transaction in order.
// The threshold register is moved through its extremes between phases.
// ----------------------------------------------------------------------------

module testbench;

  localparam int CycleLimit = 500000;
  localparam int HoldCycles = 300;
  localparam int Lanes      = mqdd_pkg::PinLanes;

  localparam logic ModeSample  = 1'b0;
  localparam logic ModeCapture = 1'b1;
  localparam logic DirCw       = 1'b0;
  localparam logic DirCcw      = 1'b1;

  localparam logic [mqdd_pkg::PAddrW-1:0] StepsAddr = {mqdd_pkg::RegStepsPerDetent, 2'b00};

  // step per {previous AB, current AB}; bounces and skipped states give zero
  localparam int QuadStep [16] = '{ 0, -1,  1,  0,
                                    1,  0,  0, -1,
                                   -1,  0,  0,  1,
                                    0,  1, -1,  0};

  typedef struct packed {
    logic [1:0] enc;
    logic       dir;
    logic       last;
  } detent_t;

  // Tracks AB states, accumulators and the threshold; queues expected detents
  class detent_scoreboard;
    logic [1:0]                      prev_ab [Lanes];
    logic signed [mqdd_pkg::AccW-1:0] acc    [Lanes];
    logic [mqdd_pkg::ThrW-1:0]       detent_steps;
    detent_t                         detent_q [$];
    int unsigned                     mismatches;

    function new();
      foreach (prev_ab[e]) begin
        prev_ab[e] = '0;
        acc[e]     = '0;
      end
      detent_steps = mqdd_pkg::StepsResetVal;
      mismatches   = 0;
    endfunction

    function int outstanding();
      return detent_q.size();
    endfunction

    function void note_sample(logic md, logic [3:0] a, logic [3:0] b);
      detent_t    hits [$];
      logic [1:0] cur;
      int         sum;
      for (int e = 0; e < Lanes; e++) begin
        cur = {a[e], b[e]};
        if (md == ModeCapture) begin
          prev_ab[e] = cur;
          acc[e]     = '0;
        end else if (cur != prev_ab[e]) begin
          sum        = int'(acc[e]) + QuadStep[{prev_ab[e], cur}];
          prev_ab[e] = cur;
          if (sum >= int'(detent_steps)) begin
            hits.push_back(detent_t'{enc: 2'(e), dir: DirCw, last: 1'b0});
            sum = 0;
          end else if (sum <= -int'(detent_steps)) begin
            hits.push_back(detent_t'{enc: 2'(e), dir: DirCcw, last: 1'b0});
            sum = 0;
          end
          acc[e] = sum[mqdd_pkg::AccW-1:0];
        end
      end
      if (hits.size() > 0) hits[hits.size()-1].last = 1'b1;
      foreach (hits[i]) detent_q.push_back(hits[i]);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_event(detent_t got);
      detent_t want;
      if (detent_q.size() == 0) begin
        report($sformatf("unexpected event enc=%0d dir=%0d last=%0d",
                         got.enc, got.dir, got.last));
        return;
      end
      want = detent_q.pop_front();
      if (got.enc !== want.enc)
        report($sformatf("encoder_index %0d, want %0d", got.enc, want.enc));
      if (got.dir !== want.dir)
        report($sformatf("direction %0d, want %0d (enc %0d)", got.dir, want.dir, want.enc));
      if (got.last !== want.last)
        report($sformatf("last_event %0d, want %0d (enc %0d)", got.last, want.last, want.enc));
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [mqdd_pkg::PAddrW-1:0]   paddr;
  logic [mqdd_pkg::PDataW-1:0]   pwdata;
  logic [mqdd_pkg::PDataW-1:0]   prdata;
  logic                          pready;

  mqdd_in_if  smp_if ();
  mqdd_out_if evt_if ();

  multi_quadrature_detent_decoder_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_s    (smp_if),
    .out_m   (evt_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  detent_scoreboard sb = new();

  logic [1:0] lane_ab [Lanes];   // last AB state sent per encoder
  int         items_sent;
  bit         hold_request;      // asks the event sink for one long hold-off
  int         cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one Gray-code step: clockwise walks 00 -> 10 -> 11 -> 01 -> 00
  function automatic logic [1:0] gray_step(logic [1:0] s, logic dir);
    return (dir == DirCw) ? {~s[0], s[1]} : {s[0], ~s[1]};
  endfunction

  task automatic send_sample(logic md, logic [3:0] a, logic [3:0] b);
    int gap;
    gap = pick_gap((items_sent / 40) % 3 == 2);
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_if.valid        <= 1'b1;
    smp_if.mode         <= md;
    smp_if.pin_a_levels <= a;
    smp_if.pin_b_levels <= b;
    do @(posedge clk_i); while (!smp_if.ready);
    sb.note_sample(md, a, b);
    for (int e = 0; e < Lanes; e++) lane_ab[e] = {a[e], b[e]};
    items_sent++;
  endtask

  task automatic send_uniform(logic md, logic [1:0] ab);
    send_sample(md, {Lanes{ab[1]}}, {Lanes{ab[0]}});
  endtask

  // drain all expected events, then give the pipeline time to go quiet
  task automatic settle_idle();
    smp_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write of the threshold, then a read back of the same register
  task automatic set_detent_steps(logic [mqdd_pkg::ThrW-1:0] steps);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= StepsAddr;
    pwdata  <= mqdd_pkg::PDataW'(steps);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.detent_steps = steps;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== mqdd_pkg::PDataW'(steps))
      sb.report($sformatf("steps_per_detent reads %0h, want %0h", prdata, steps));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // event sink: random stalls, calm stretches, one long hold-off on request
  initial begin : event_sink
    int stall;
    int rx_cycles;
    bit held;
    stall        = 0;
    rx_cycles    = 0;
    held         = 1'b0;
    evt_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycles++;
      if (evt_if.valid && evt_if.ready)
        sb.check_event(detent_t'{enc: evt_if.encoder_index, dir: evt_if.direction,
                                 last: evt_if.last_event});
      if (hold_request && !held) begin
        held  = 1'b1;
        stall = HoldCycles;
      end
      if (stall > 0) begin
        evt_if.ready <= 1'b0;
        stall--;
      end else begin
        evt_if.ready <= 1'b1;
        stall = pick_gap((rx_cycles / 300) % 4 == 3);
      end
    end
  end

  initial begin : sample_source
    logic [mqdd_pkg::ThrW-1:0] phase_steps [6];
    logic                      heading [Lanes];
    logic [1:0]                ab;
    logic [1:0]                nxt;
    logic [3:0]                a;
    logic [3:0]                b;
    logic                      md;
    int                        pick;

    phase_steps  = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5};
    phase_steps[4] = 4'($urandom_range(1, 8));
    items_sent   = 0;
    hold_request = 1'b0;
    for (int e = 0; e < Lanes; e++) begin
      lane_ab[e] = 2'b00;
      heading[e] = DirCw;
    end

    rst_ni              = 1'b0;
    smp_if.valid        = 1'b0;
    smp_if.mode         = ModeSample;
    smp_if.pin_a_levels = '0;
    smp_if.pin_b_levels = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed, reset threshold of 4 ---
    send_uniform(ModeSample, 2'b00);        // unchanged state, nothing raised
    send_uniform(ModeCapture, 2'b10);       // capture raises nothing
    ab = 2'b10;
    repeat (4) begin                        // full cw detent on all four
      ab = gray_step(ab, DirCw);
      send_uniform(ModeSample, ab);
    end
    repeat (4) begin                        // full ccw detent on all four
      ab = gray_step(ab, DirCcw);
      send_uniform(ModeSample, ab);
    end
    send_uniform(ModeSample, ab ^ 2'b11);   // bounce: changed, zero step
    send_uniform(ModeCapture, 2'b01);

    // threshold lowered under an accumulator already past it
    settle_idle();
    set_detent_steps(4'd8);
    send_uniform(ModeCapture, 2'b00);
    ab = 2'b00;
    repeat (5) begin
      ab = gray_step(ab, DirCw);
      send_uniform(ModeSample, ab);
    end
    settle_idle();
    set_detent_steps(4'd2);
    ab = gray_step(ab, DirCw);
    send_uniform(ModeSample, ab);

    // zero threshold: every state change fires, bounces included
    settle_idle();
    set_detent_steps(4'd0);
    ab = ab ^ 2'b11;
    send_uniform(ModeSample, ab);
    ab = gray_step(ab, DirCcw);
    send_uniform(ModeSample, ab);

    // --- random phases: mostly Gray walks with a persistent heading ---
    for (int ph = 0; ph < 6; ph++) begin
      settle_idle();
      set_detent_steps(phase_steps[ph]);
      for (int k = 0; k < 60; k++) begin
        if (ph == 0 && k == 20) hold_request = 1'b1;
        md = ($urandom_range(0, 99) < 3) ? ModeCapture : ModeSample;
        if ($urandom_range(0, 99) < 8) begin
          a = 4'($urandom);
          b = 4'($urandom);
        end else begin
          for (int e = 0; e < Lanes; e++) begin
            if ($urandom_range(0, 99) < 5) heading[e] = ~heading[e];
            pick = $urandom_range(0, 99);
            nxt  = lane_ab[e];
            if (pick >= 92)      nxt = lane_ab[e] ^ 2'b11;
            else if (pick >= 35) nxt = gray_step(lane_ab[e], heading[e]);
            a[e] = nxt[1];
            b[e] = nxt[0];
          end
        end
        send_sample(md, a, b);
      end
    end

    settle_idle();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
